FILE: rtl/olib_pkg.sv
// ----------------------------------------------------------------------------
// olib_pkg: shared definitions for the ordered list block
// Sizes, action and status codes, entry and memory request types.
// ----------------------------------------------------------------------------
package olib_pkg;

	localparam int MAX_ENTRIES  = 64;
	localparam int RESULT_LIMIT = 64;
	localparam int IDX_W        = $clog2(MAX_ENTRIES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int KEY_W        = 32;
	localparam int PAY_W        = 64;
	localparam int POS_W        = 6;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_DUMP   = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_EMPTY    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_PUT,
		ST_RESP,
		ST_DUMP
	} state_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_req_t;

	// position modulo 2**POS_W
	function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
		logic [CNT_W+POS_W-1:0] w;
		w = {{POS_W{1'b0}}, v};
		return w[POS_W-1:0];
	endfunction

endpackage

FILE: rtl/olib_store.sv
// ----------------------------------------------------------------------------
// olib_store: entry memory
// One write port and one read port, read data registered, held between reads.
// ----------------------------------------------------------------------------
module olib_store import olib_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rd_data
);

	entry_t mem [MAX_ENTRIES];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

FILE: rtl/ordered_list_insert_before_key.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_before_key: bounded ordered list with insert-before
// Append, insert ahead of the first matching key, and dump of all entries.
// ----------------------------------------------------------------------------
// insert-before searches from the head for the first key equal to the target; an empty
//   list or no match gives not found, a match on a full list gives full, otherwise the
//   entries from the tail down to the match move back one slot, one entry a cycle
// dump: one word per cycle after the first while the output can take it, up to 64 words
// input words are taken only in idle, once the previous word's last output is registered;
//   reset clears the count and control, the entry memory is read only below the count
module ordered_list_insert_before_key import olib_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // entry_key, entry_payload, target_key
	input  logic [1:0]   s_tuser,  // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,  // out_key, out_payload, out_position, zero pad
	output logic [1:0]   m_tuser,  // status
	output logic         m_tlast
);

	localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_ENTRIES);
	localparam logic [CNT_W-1:0] LIMIT_C = (RESULT_LIMIT < MAX_ENTRIES) ?
		CNT_W'(RESULT_LIMIT) : CNT_W'(MAX_ENTRIES);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] ri_s1, ri_d;
	logic             rv_s1, rv_d;
	logic             stop_q, stop_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] emit_q, emit_d;
	logic [1:0]       res_status_q, res_status_d;
	logic [POS_W-1:0] res_pos_q, res_pos_d;
	entry_t           new_q, new_d;
	logic [KEY_W-1:0] tgt_q, tgt_d;

	logic             m_valid_q, m_valid_d;
	logic             m_last_q, m_last_d;
	logic [1:0]       m_status_q, m_status_d;
	entry_t           m_entry_q, m_entry_d;
	logic [POS_W-1:0] m_pos_q, m_pos_d;

	mem_req_t req;
	entry_t   rd_data;
	logic     out_free;
	logic [CNT_W-1:0] wr_next;

	olib_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	assign out_free = !m_valid_q || m_tready;
	assign wr_next  = ri_s1 + ONE_C;

	function automatic logic [IDX_W-1:0] wr_next_dump(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] n;
		n = v + ONE_C;
		return n[IDX_W-1:0];
	endfunction

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		idx_d        = idx_q;
		ri_d         = ri_s1;
		rv_d         = 1'b0;
		stop_d       = stop_q;
		pos_d        = pos_q;
		emit_d       = emit_q;
		res_status_d = res_status_q;
		res_pos_d    = res_pos_q;
		new_d        = new_q;
		tgt_d        = tgt_q;
		m_valid_d    = m_valid_q && !m_tready;
		m_last_d     = m_last_q;
		m_status_d   = m_status_q;
		m_entry_d    = m_entry_q;
		m_pos_d      = m_pos_q;
		req          = '0;
		s_tready     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					new_d.key     = s_tdata[31:0];
					new_d.payload = s_tdata[95:32];
					tgt_d         = s_tdata[127:96];
					unique case (s_tuser)
						ACT_APPEND: begin
							res_pos_d = '0;
							state_d   = ST_RESP;
							if (cnt_q >= MAX_C) begin
								res_status_d = STAT_FULL;
							end else begin
								req.wr_en    = 1'b1;
								req.wr_addr  = cnt_q[IDX_W-1:0];
								req.wr_data.key     = s_tdata[31:0];
								req.wr_data.payload = s_tdata[95:32];
								cnt_d        = cnt_q + ONE_C;
								res_status_d = STAT_OK;
								res_pos_d    = to_pos(cnt_q);
							end
						end
						ACT_INSERT: begin
							if (cnt_q == '0) begin
								res_status_d = STAT_NOTFOUND;
								res_pos_d    = '0;
								state_d      = ST_RESP;
							end else begin
								idx_d   = '0;
								state_d = ST_SEARCH;
							end
						end
						ACT_DUMP: begin
							if (cnt_q == '0) begin
								res_status_d = STAT_EMPTY;
								res_pos_d    = '0;
								state_d      = ST_RESP;
							end else begin
								req.rd_en   = 1'b1;
								req.rd_addr = '0;
								idx_d       = '0;
								emit_d      = (cnt_q > LIMIT_C) ? LIMIT_C : cnt_q;
								state_d     = ST_DUMP;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end

			ST_SEARCH: begin
				if (rv_s1 && rd_data.key == tgt_q) begin
					if (cnt_q >= MAX_C) begin
						res_status_d = STAT_FULL;
						res_pos_d    = '0;
						state_d      = ST_RESP;
					end else begin
						pos_d   = ri_s1;
						idx_d   = cnt_q - ONE_C;
						stop_d  = 1'b0;
						state_d = ST_SHIFT;
					end
				end else if (rv_s1 && ri_s1 == cnt_q - ONE_C) begin
					res_status_d = STAT_NOTFOUND;
					res_pos_d    = '0;
					state_d      = ST_RESP;
				end else if (idx_q < cnt_q) begin
					req.rd_en   = 1'b1;
					req.rd_addr = idx_q[IDX_W-1:0];
					rv_d        = 1'b1;
					ri_d        = idx_q;
					idx_d       = idx_q + ONE_C;
				end
			end

			ST_SHIFT: begin
				// move entries back by one from the tail down to the match
				if (rv_s1) begin
					req.wr_en   = 1'b1;
					req.wr_addr = wr_next[IDX_W-1:0];
					req.wr_data = rd_data;
				end
				if (rv_s1 && ri_s1 == pos_q) begin
					state_d = ST_PUT;
				end else if (!stop_q) begin
					req.rd_en   = 1'b1;
					req.rd_addr = idx_q[IDX_W-1:0];
					rv_d        = 1'b1;
					ri_d        = idx_q;
					if (idx_q == pos_q) begin
						stop_d = 1'b1;
					end else begin
						idx_d = idx_q - ONE_C;
					end
				end
			end

			ST_PUT: begin
				req.wr_en    = 1'b1;
				req.wr_addr  = pos_q[IDX_W-1:0];
				req.wr_data  = new_q;
				cnt_d        = cnt_q + ONE_C;
				res_status_d = STAT_OK;
				res_pos_d    = to_pos(pos_q);
				state_d      = ST_RESP;
			end

			ST_RESP: begin
				if (out_free) begin
					m_valid_d  = 1'b1;
					m_last_d   = 1'b1;
					m_status_d = res_status_q;
					m_entry_d  = '0;
					m_pos_d    = res_pos_q;
					state_d    = ST_IDLE;
				end
			end

			ST_DUMP: begin
				// read data holds entry idx_q until the output register takes it
				if (out_free) begin
					m_valid_d  = 1'b1;
					m_status_d = STAT_OK;
					m_entry_d  = rd_data;
					m_pos_d    = to_pos(idx_q);
					m_last_d   = (idx_q == emit_q - ONE_C);
					if (idx_q == emit_q - ONE_C) begin
						state_d = ST_IDLE;
					end else begin
						req.rd_en   = 1'b1;
						req.rd_addr = wr_next_dump(idx_q);
						idx_d       = idx_q + ONE_C;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rv_s1     <= 1'b0;
			stop_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			rv_s1     <= rv_d;
			stop_q    <= stop_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		ri_s1        <= ri_d;
		pos_q        <= pos_d;
		emit_q       <= emit_d;
		res_status_q <= res_status_d;
		res_pos_q    <= res_pos_d;
		new_q        <= new_d;
		tgt_q        <= tgt_d;
		m_last_q     <= m_last_d;
		m_status_q   <= m_status_d;
		m_entry_q    <= m_entry_d;
		m_pos_q      <= m_pos_d;
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {2'b00, m_pos_q, m_entry_q.payload, m_entry_q.key};

	// count never passes the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_C)
		else $error("entry count beyond capacity");

	// the count only ever grows by one
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + ONE_C)
		else $error("entry count changed by more than one");

	// writes stay inside the list plus the slot just past its tail
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> {1'b0, req.wr_addr} <= cnt_q)
		else $error("memory write beyond list tail");

	// error and empty-dump words always end their run
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tlast)
		else $error("status word without last marker");

endmodule

FILE: tb/ordered_list_insert_before_key_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_before_key_tb: self-checking bench for the ordered list
// Drives append, insert-before, dump and unused-action words on the input
// stream and keeps its own copy of the list to predict every output word.
// Covers empty and full lists, duplicate keys and missing keys. Both sides
// stall at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module ordered_list_insert_before_key_tb;
	import olib_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int HOLD_CYCLES  = 500;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam int TOTAL_ITEMS  = 400;
	localparam int QUIET_ITEMS  = 40;

	typedef struct {
		logic [1:0]       status;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic [POS_W-1:0] position;
		logic             last;
	} list_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	// shadow copy of the list, in list order
	logic [KEY_W-1:0] list_keys [MAX_ENTRIES];
	logic [PAY_W-1:0] list_payloads [MAX_ENTRIES];
	int               list_len = 0;

	list_result_t pending_results [$];

	bit sender_gaps = 1'b1;
	bit receiver_gaps = 1'b1;
	bit hold_request = 1'b0;
	int items_sent = 0;
	int results_checked = 0;
	int inserts_placed = 0;
	int dumps_sent = 0;
	int error_count = 0;
	int stall_cycles = 0;

	ordered_list_insert_before_key uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	task automatic apply_list_op(input logic [1:0] act, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] payload, input logic [KEY_W-1:0] target);
		int hit;
		int emit;
		list_result_t r;
		r.status = STAT_OK;
		r.key = '0;
		r.payload = '0;
		r.position = '0;
		r.last = 1'b1;
		case (act)
		ACT_APPEND: begin
			if (list_len >= MAX_ENTRIES) begin
				r.status = STAT_FULL;
			end else begin
				list_keys[list_len] = key;
				list_payloads[list_len] = payload;
				r.position = POS_W'(list_len);
				list_len++;
			end
			pending_results.push_back(r);
		end
		ACT_INSERT: begin
			hit = -1;
			for (int i = 0; i < list_len; i++)
				if (hit < 0 && list_keys[i] == target)
					hit = i;
			// a missing key wins over a full list
			if (hit < 0) begin
				r.status = STAT_NOTFOUND;
			end else if (list_len >= MAX_ENTRIES) begin
				r.status = STAT_FULL;
			end else begin
				for (int i = list_len; i > hit; i--) begin
					list_keys[i] = list_keys[i-1];
					list_payloads[i] = list_payloads[i-1];
				end
				list_keys[hit] = key;
				list_payloads[hit] = payload;
				r.position = POS_W'(hit);
				list_len++;
				inserts_placed++;
			end
			pending_results.push_back(r);
		end
		ACT_DUMP: begin
			dumps_sent++;
			if (list_len == 0) begin
				r.status = STAT_EMPTY;
				pending_results.push_back(r);
			end else begin
				emit = (list_len > RESULT_LIMIT) ? RESULT_LIMIT : list_len;
				for (int i = 0; i < emit; i++) begin
					r.key = list_keys[i];
					r.payload = list_payloads[i];
					r.position = POS_W'(i);
					r.last = (i == emit - 1);
					pending_results.push_back(r);
				end
			end
		end
		default: ;
		endcase
	endtask

	// offers one word, waits for it to be taken, then maybe pauses
	task automatic send_word(input logic [1:0] act, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] payload, input logic [KEY_W-1:0] target);
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {target, payload, key};
		do @(posedge clk); while (!s_tready);
		apply_list_op(act, key, payload, target);
		if (act != ACT_UNUSED)
			items_sent++;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// small keys collide often, so matches and duplicates are common
	function automatic logic [KEY_W-1:0] rand_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return KEY_W'($urandom_range(0, 15));
		if (r == 4) begin
			case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			default: return 32'hffff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [KEY_W-1:0] pick_target();
		if (list_len > 0 && $urandom_range(0, 3) != 0)
			return list_keys[$urandom_range(0, list_len - 1)];
		return rand_key();
	endfunction

	task automatic send_random_item(input int dump_pct);
		int r;
		logic [1:0] act;
		r = $urandom_range(0, 99);
		if (r < 35)
			act = ACT_APPEND;
		else if (r < 97 - dump_pct)
			act = ACT_INSERT;
		else if (r < 97)
			act = ACT_DUMP;
		else
			act = ACT_UNUSED;
		send_word(act, rand_key(), {$urandom, $urandom}, pick_target());
	endtask

	task automatic test_empty_list();
		send_word(ACT_DUMP, '0, '0, '0);
		send_word(ACT_INSERT, 32'd1, 64'h1, 32'd1);
		send_word(ACT_UNUSED, '1, '1, '1);
		send_word(ACT_DUMP, '1, '1, '1);
	endtask

	task automatic test_directed_edits();
		send_word(ACT_APPEND, 32'h8000_0000, 64'h0, 32'h0);
		send_word(ACT_APPEND, 32'h7fff_ffff, '1, 32'hffff_ffff);
		send_word(ACT_APPEND, 32'h0, 64'h0123_4567_89ab_cdef, 32'h0);
		send_word(ACT_APPEND, 32'hffff_ffff, 64'hfedc_ba98_7654_3210, 32'h0);
		// ahead of the head
		send_word(ACT_INSERT, 32'd5, 64'ha5a5_a5a5_a5a5_a5a5, 32'h8000_0000);
		// ahead of the tail, with a second key 5
		send_word(ACT_INSERT, 32'd5, 64'h5a5a_5a5a_5a5a_5a5a, 32'hffff_ffff);
		// only the first key 5 counts
		send_word(ACT_INSERT, 32'd7, 64'h8000_0000_0000_0001, 32'd5);
		send_word(ACT_INSERT, 32'd9, 64'h7fff_ffff_ffff_fffe, 32'h7fff_ffff);
		send_word(ACT_INSERT, 32'd11, 64'hdead_beef_0bad_f00d, 32'd1234);
		send_word(ACT_UNUSED, 32'd3, 64'h3, 32'd5);
		send_word(ACT_DUMP, '0, '0, '0);
	endtask

	task automatic test_grow_to_full();
		bit hold_done;
		hold_done = 1'b0;
		while (list_len < MAX_ENTRIES) begin
			if (!hold_done && list_len >= 24) begin
				// output held off while a dump and more words queue up
				hold_done = 1'b1;
				hold_request = 1'b1;
				send_word(ACT_DUMP, '0, '0, '0);
			end
			send_random_item(10);
		end
	endtask

	task automatic test_full_list();
		logic [KEY_W-1:0] absent;
		bit found;
		send_word(ACT_APPEND, 32'h1357_9bdf, '1, '0);
		send_word(ACT_INSERT, 32'h2468_ace0, '1, list_keys[$urandom_range(0, MAX_ENTRIES - 1)]);
		do begin
			absent = $urandom;
			found = 1'b0;
			for (int i = 0; i < list_len; i++)
				if (list_keys[i] == absent)
					found = 1'b1;
		end while (found);
		send_word(ACT_INSERT, 32'h0, '0, absent);
		send_word(ACT_DUMP, '0, '0, '0);
	endtask

	task automatic test_random_full();
		int n;
		n = 0;
		while (items_sent < TOTAL_ITEMS - QUIET_ITEMS) begin
			// alternate stretches with and without sender pauses
			if (n % 50 == 0)
				sender_gaps = !sender_gaps;
			send_random_item(6);
			n++;
		end
	endtask

	task automatic test_back_to_back();
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		repeat (QUIET_ITEMS) send_random_item(6);
	endtask

	// output side: random stalls, and the long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		list_result_t exp;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				$error("output word with nothing expected: status %0d key %h",
					m_tuser, m_tdata[31:0]);
				error_count++;
			end else begin
				exp = pending_results.pop_front();
				if (m_tuser !== exp.status) begin
					$error("status: expected %0d, got %0d", exp.status, m_tuser);
					error_count++;
				end
				if (m_tdata[31:0] !== exp.key) begin
					$error("out_key: expected %h, got %h", exp.key, m_tdata[31:0]);
					error_count++;
				end
				if (m_tdata[95:32] !== exp.payload) begin
					$error("out_payload: expected %h, got %h", exp.payload, m_tdata[95:32]);
					error_count++;
				end
				if (m_tdata[101:96] !== exp.position) begin
					$error("out_position: expected %0d, got %0d", exp.position,
						m_tdata[101:96]);
					error_count++;
				end
				if (m_tlast !== exp.last) begin
					$error("last: expected %0d, got %0d", exp.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: %0d words still expected", pending_results.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_directed_edits();
		test_grow_to_full();
		test_full_list();
		test_random_full();
		test_back_to_back();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d input words (%0d dumps, %0d inserts placed)",
			items_sent, dumps_sent, inserts_placed);
		$display("checked %0d output words, final list length %0d, %0d mismatches",
			results_checked, list_len, error_count);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/olib_pkg.sv
rtl/olib_store.sv
rtl/ordered_list_insert_before_key.sv
tb/ordered_list_insert_before_key_tb.sv
